[rtl/core/slmb_pkg.sv]
// ----------------------------------------------------------------------------
// slmb_pkg
// Shared types and constants of the stereo level meter bar block.
// ----------------------------------------------------------------------------
package slmb_pkg;

    localparam int DIGIT_COUNT = 16;
    localparam int CNT_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    localparam int LEVEL_W     = 24;
    localparam int BAR_SHIFT   = 17;
    localparam int PEAK_DISP   = 18;
    localparam int BAR_W       = LEVEL_W - BAR_SHIFT;
    localparam int PEAK_W      = LEVEL_W - PEAK_DISP;

    localparam int FQ_DEPTH    = 4;
    localparam int FQ_PTR_W    = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W    = $clog2(FQ_DEPTH + 1);

    localparam int SHIFT_W     = 4;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_AVG_SHIFT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_SHIFT = 1'b1;

    localparam logic [SHIFT_W-1:0] AVG_SHIFT_RESET  = 4'd9;
    localparam logic [SHIFT_W-1:0] PEAK_SHIFT_RESET = 4'd6;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FRAME  = 1'b1;

    localparam logic [7:0] SEG_L_HALF  = 8'b0010_0000;
    localparam logic [7:0] SEG_L_FULL  = 8'b0010_0010;
    localparam logic [7:0] SEG_R_HALF  = 8'b0001_0000;
    localparam logic [7:0] SEG_R_FULL  = 8'b0001_0100;
    localparam logic [7:0] SEG_PL_ODD  = 8'b0000_0010;
    localparam logic [7:0] SEG_PL_EVEN = 8'b0010_0000;
    localparam logic [7:0] SEG_PR_ODD  = 8'b0001_0000;
    localparam logic [7:0] SEG_PR_EVEN = 8'b0000_0100;

    typedef struct packed {
        logic        operation;
        logic [31:0] raw_word;
        logic        channel;
    } slmb_item_t;

    typedef struct packed {
        logic [3:0] digit_index;
        logic [7:0] segment_bits;
        logic       last_digit;
    } slmb_result_t;

    // snapshot of both channels taken when a frame tick is applied
    typedef struct packed {
        logic [BAR_W-1:0]  bar_l;
        logic [BAR_W-1:0]  bar_r;
        logic [PEAK_W-1:0] peak_l;
        logic [PEAK_W-1:0] peak_r;
    } frame_desc_t;

    typedef struct packed {
        logic almost_full;
        logic nonempty;
    } fq_status_t;

endpackage

[rtl/core/slmb_front.sv]
// ----------------------------------------------------------------------------
// slmb_front
// Takes items, keeps per-channel average and peak, and snapshots frame ticks.
// ----------------------------------------------------------------------------
module slmb_front
    import slmb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  slmb_item_t             item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SHIFT_W-1:0]     cfg_data,
    output logic                   q_push,
    output frame_desc_t            q_desc
);

    logic [SHIFT_W-1:0] avg_shift_reg;
    logic [SHIFT_W-1:0] peak_shift_reg;

    logic               s1_valid_reg;
    logic               s1_frame_reg;
    logic               s1_channel_reg;
    logic [LEVEL_W-1:0] s1_mag_reg;

    logic [LEVEL_W-1:0] avg_reg  [2];
    logic [LEVEL_W-1:0] peak_reg [2];

    logic [LEVEL_W-1:0] sample;
    logic [LEVEL_W-1:0] mag_next;
    logic [LEVEL_W-1:0] avg_next;
    logic [LEVEL_W-1:0] peak_l_next;
    logic [LEVEL_W-1:0] peak_r_next;

    // (old*(2^k-1)+in)>>k, done as (old<<k)-old+in
    function automatic logic [LEVEL_W-1:0] leak(input logic [LEVEL_W-1:0] old,
                                                input logic [LEVEL_W-1:0] in,
                                                input logic [SHIFT_W-1:0] k);
        logic [39:0] acc;
        acc = (40'(old) << k) - 40'(old) + 40'(in);
        acc = acc >> k;
        return acc[LEVEL_W-1:0];
    endfunction

    assign sample   = item.raw_word[27:4];
    assign mag_next = sample[LEVEL_W-1] ? (~sample + 1'b1) : sample;

    assign avg_next    = leak(avg_reg[s1_channel_reg], s1_mag_reg, avg_shift_reg);
    assign peak_l_next = leak(peak_reg[0], avg_reg[0], peak_shift_reg);
    assign peak_r_next = leak(peak_reg[1], avg_reg[1], peak_shift_reg);

    assign q_push        = s1_valid_reg && s1_frame_reg;
    assign q_desc.bar_l  = avg_reg[0][LEVEL_W-1:BAR_SHIFT];
    assign q_desc.bar_r  = avg_reg[1][LEVEL_W-1:BAR_SHIFT];
    assign q_desc.peak_l = peak_reg[0][LEVEL_W-1:PEAK_DISP];
    assign q_desc.peak_r = peak_reg[1][LEVEL_W-1:PEAK_DISP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_shift_reg  <= AVG_SHIFT_RESET;
            peak_shift_reg <= PEAK_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AVG_SHIFT:  avg_shift_reg  <= cfg_data;
                REG_PEAK_SHIFT: peak_shift_reg <= cfg_data;
            endcase
        end
    end

    // decode stage: classify and take the magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_frame_reg   <= (item.operation == OP_FRAME);
            s1_channel_reg <= item.channel;
            s1_mag_reg     <= mag_next;
        end
    end

    // apply stage: update levels, decay peaks after a frame snapshot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg[0]  <= '0;
            avg_reg[1]  <= '0;
            peak_reg[0] <= '0;
            peak_reg[1] <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_frame_reg)
            begin
                peak_reg[0] <= peak_l_next;
                peak_reg[1] <= peak_r_next;
            end
            else
            begin
                avg_reg[s1_channel_reg] <= avg_next;
                if (s1_mag_reg > peak_reg[s1_channel_reg])
                    peak_reg[s1_channel_reg] <= s1_mag_reg;
            end
        end
    end

endmodule

[rtl/core/slmb_frame_queue.sv]
// ----------------------------------------------------------------------------
// slmb_frame_queue
// Short queue of frame snapshots between the level tracker and the sequencer.
// ----------------------------------------------------------------------------
module slmb_frame_queue
    import slmb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_desc_t push_desc,
    input  logic        pop,
    output frame_desc_t head_desc,
    output fq_status_t  status
);

    frame_desc_t         mem_reg [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] wr_ptr_reg;
    logic [FQ_PTR_W-1:0] rd_ptr_reg;
    logic [FQ_CNT_W-1:0] count_reg;

    assign head_desc          = mem_reg[rd_ptr_reg];
    // leave one slot for a frame still in the decode stage
    assign status.almost_full = (count_reg >= FQ_CNT_W'(FQ_DEPTH - 1));
    assign status.nonempty    = (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != FQ_CNT_W'(FQ_DEPTH))
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.nonempty)
        else $error("frame queue underflow");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && pop |=> $stable(count_reg))
        else $error("frame queue count moved on simultaneous push and pop");

endmodule

[rtl/core/slmb_back.sv]
// ----------------------------------------------------------------------------
// slmb_back
// Digit sequencer: expands one frame snapshot into segment bytes.
// ----------------------------------------------------------------------------
module slmb_back
    import slmb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         desc_valid,
    input  frame_desc_t  desc,
    output logic         desc_pop,
    input  logic         pop,
    output logic         out_valid,
    output slmb_result_t result
);

    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(DIGIT_COUNT - 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    slmb_result_t     result_reg;

    logic             load;
    logic             last;
    logic [7:0]       two_i;
    logic [7:0]       seg_next;

    assign load  = desc_valid && (!out_valid_reg || pop);
    assign last  = (cnt_reg == LAST_DIGIT);
    assign two_i = 8'(cnt_reg) << 1;

    always_comb
    begin
        seg_next = '0;
        if (8'(desc.bar_l) == two_i + 8'd1)
            seg_next = seg_next | SEG_L_HALF;
        else if (8'(desc.bar_l) >= two_i + 8'd2)
            seg_next = seg_next | SEG_L_FULL;
        if (8'(desc.bar_r) == two_i + 8'd1)
            seg_next = seg_next | SEG_R_HALF;
        else if (8'(desc.bar_r) >= two_i + 8'd2)
            seg_next = seg_next | SEG_R_FULL;
        // markers past the last digit never match the counter, so they drop
        if (8'(desc.peak_l[PEAK_W-1:1]) == 8'(cnt_reg))
            seg_next = seg_next | (desc.peak_l[0] ? SEG_PL_ODD : SEG_PL_EVEN);
        if (8'(desc.peak_r[PEAK_W-1:1]) == 8'(cnt_reg))
            seg_next = seg_next | (desc.peak_r[0] ? SEG_PR_ODD : SEG_PR_EVEN);
    end

    assign desc_pop  = load && last;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            cnt_reg       <= last ? '0 : cnt_reg + 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.digit_index  <= 4'(cnt_reg);
            result_reg.segment_bits <= seg_next;
            result_reg.last_digit   <= last;
        end
    end

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        desc_pop |=> out_valid_reg && result_reg.last_digit && cnt_reg == '0)
        else $error("frame released without its last digit");

endmodule

[rtl/core/stereo_level_meter_bar.sv]
// ----------------------------------------------------------------------------
// stereo_level_meter_bar
// Stereo level meter with peak hold that renders a bar display frame.
// ----------------------------------------------------------------------------
// A sample word is accepted every cycle while full is low, decoded in one
// stage and applied to the channel's average and peak in the next. A frame
// tick is snapshotted into a four-entry frame queue and then yields
// DIGIT_COUNT (16) result words from the digit sequencer, one per cycle
// while results are popped; on its way to the result ports the tick passes
// the decode stage, the frame queue and the sequencer's result register.
// Full is high while three or more frames wait in the queue; samples keep
// flowing otherwise, even while results stall.
module stereo_level_meter_bar
    import slmb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  slmb_item_t             item,
    output logic                   empty,
    input  logic                   pop,
    output slmb_result_t           result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SHIFT_W-1:0]     cfg_data
);

    logic        accept;
    logic        q_push;
    logic        q_pop;
    frame_desc_t q_desc;
    frame_desc_t head_desc;
    fq_status_t  q_status;
    logic        out_valid;

    assign full   = q_status.almost_full;
    assign accept = push && !full;
    assign empty  = !out_valid;

    slmb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_desc    (q_desc)
    );

    slmb_frame_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_desc),
        .pop       (q_pop),
        .head_desc (head_desc),
        .status    (q_status)
    );

    slmb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (q_status.nonempty),
        .desc       (head_desc),
        .desc_pop   (q_pop),
        .pop        (pop && !empty),
        .out_valid  (out_valid),
        .result     (result)
    );

endmodule

[tb/stereo_level_meter_bar_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_level_meter_bar_tb
// Self-checking bench for the stereo level meter: a local model tracks both
// channel averages and peaks, expands every frame tick into its 16 digit
// words and checks the block's output stream under random input bursts,
// output stalls and several shift settings.
// ----------------------------------------------------------------------------
module stereo_level_meter_bar_tb;
    import slmb_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTS    = 40;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    slmb_item_t             stim_word = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    slmb_result_t           out_word;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SHIFT_W-1:0]     cfg_data = '0;

    // local copy of the meter state and its two shift registers
    logic [LEVEL_W-1:0] level_avg [2];
    logic [LEVEL_W-1:0] level_pk [2];
    logic [SHIFT_W-1:0] avg_k;
    logic [SHIFT_W-1:0] peak_k;

    slmb_item_t   pending_items [$];
    slmb_result_t expected_digits [$];
    slmb_result_t want_word;

    int error_count = 0;
    int quiet_cycles = 0;
    logic word_taken = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int pat_mode = 0;
    int pat_left = 0;

    stereo_level_meter_bar dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (stim_word),
        .empty     (empty),
        .pop       (pop),
        .result    (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH: %s", msg);
    endtask

    // (old*(2^k-1)+in)>>k, kept to the level width
    function automatic logic [LEVEL_W-1:0] leaky_mix(input logic [LEVEL_W-1:0] old_lvl,
                                                     input logic [LEVEL_W-1:0] in_lvl,
                                                     input logic [SHIFT_W-1:0] k);
        logic [63:0] acc;
        acc = (64'(old_lvl) * ((64'd1 << k) - 64'd1) + 64'(in_lvl)) >> k;
        return acc[LEVEL_W-1:0];
    endfunction

    task automatic meter_take(input slmb_item_t w);
        logic [LEVEL_W-1:0] s;
        logic [LEVEL_W-1:0] mag;
        logic [7:0]         segs [DIGIT_COUNT];
        logic [PEAK_W-1:0]  pk_l;
        logic [PEAK_W-1:0]  pk_r;
        slmb_result_t       r;
        int                 bar_l;
        int                 bar_r;
        int                 dl;
        int                 dr;
        if (w.operation == OP_SAMPLE)
        begin
            s = w.raw_word[27:4];
            mag = s[LEVEL_W-1] ? (~s + 24'd1) : s;
            level_avg[w.channel] = leaky_mix(level_avg[w.channel], mag, avg_k);
            if (mag > level_pk[w.channel])
                level_pk[w.channel] = mag;
            return;
        end
        bar_l = int'(level_avg[0] >> BAR_SHIFT);
        bar_r = int'(level_avg[1] >> BAR_SHIFT);
        pk_l = PEAK_W'(level_pk[0] >> PEAK_DISP);
        pk_r = PEAK_W'(level_pk[1] >> PEAK_DISP);
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            segs[i] = 8'h00;
            dl = bar_l - 2 * i;
            dr = bar_r - 2 * i;
            if (dl == 1)
                segs[i] |= SEG_L_HALF;
            else if (dl >= 2)
                segs[i] |= SEG_L_FULL;
            if (dr == 1)
                segs[i] |= SEG_R_HALF;
            else if (dr >= 2)
                segs[i] |= SEG_R_FULL;
        end
        // drop a peak marker that falls past the last digit
        if ((pk_l >> 1) < DIGIT_COUNT)
            segs[pk_l >> 1] |= pk_l[0] ? SEG_PL_ODD : SEG_PL_EVEN;
        if ((pk_r >> 1) < DIGIT_COUNT)
            segs[pk_r >> 1] |= pk_r[0] ? SEG_PR_ODD : SEG_PR_EVEN;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            r.digit_index  = 4'(i);
            r.segment_bits = segs[i];
            r.last_digit   = (i == DIGIT_COUNT - 1);
            expected_digits.push_back(r);
        end
        level_pk[0] = leaky_mix(level_pk[0], level_avg[0], peak_k);
        level_pk[1] = leaky_mix(level_pk[1], level_avg[1], peak_k);
    endtask

    // input side: record each accepted word and advance the local model
    always @(posedge clk)
    begin
        word_taken <= rst_n && push && !full;
        if (rst_n && push && !full)
            meter_take(stim_word);
    end

    // output side: check each accepted word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_digits.size() == 0)
                report_mismatch($sformatf("unexpected word %p", out_word));
            else
            begin
                want_word = expected_digits.pop_front();
                if (out_word.digit_index !== want_word.digit_index)
                    report_mismatch($sformatf("digit_index got %0d want %0d",
                                              out_word.digit_index, want_word.digit_index));
                if (out_word.segment_bits !== want_word.segment_bits)
                    report_mismatch($sformatf("segment_bits digit %0d got %02h want %02h",
                                              want_word.digit_index, out_word.segment_bits,
                                              want_word.segment_bits));
                if (out_word.last_digit !== want_word.last_digit)
                    report_mismatch($sformatf("last_digit digit %0d got %0b want %0b",
                                              want_word.digit_index, out_word.last_digit,
                                              want_word.last_digit));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("stereo_level_meter_bar_tb failed");
            $finish;
        end
    end

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (!push || word_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                stim_word <= pending_items.pop_front();
                push <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            burst_left = $urandom_range(30, 60);
                            gap_left = 0;
                        end
                        1:
                        begin
                            burst_left = $urandom_range(1, 4);
                            gap_left = $urandom_range(1, 3);
                        end
                        2:
                        begin
                            burst_left = $urandom_range(1, 10);
                            gap_left = $urandom_range(0, 15);
                        end
                        default:
                        begin
                            burst_left = 0;
                            gap_left = 1;
                        end
                    endcase
                end
            end
            else
                push <= 1'b0;
        end
    end

    // receiver: changing stall pattern, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (pat_left == 0)
        begin
            pat_mode = $urandom_range(0, 2);
            pat_left = $urandom_range(10, 80);
        end
        else
            pat_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            case (pat_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                default: pop <= (pat_left % 4 == 0);
            endcase
        end
    end

    function automatic slmb_item_t sample_word(input logic ch, input logic [LEVEL_W-1:0] lvl);
        slmb_item_t w;
        w.operation = OP_SAMPLE;
        w.raw_word  = {4'($urandom), lvl, 4'($urandom)};
        w.channel   = ch;
        return w;
    endfunction

    function automatic slmb_item_t frame_word();
        slmb_item_t w;
        w.operation = OP_FRAME;
        w.raw_word  = $urandom;
        w.channel   = 1'($urandom);
        return w;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return LEVEL_W'($urandom);
            1:       return 24'h7FFFFF - LEVEL_W'($urandom_range(0, 24'h1FFFFF));
            2:       return 24'h800000 + LEVEL_W'($urandom_range(0, 24'h1FFFFF));
            3:       return LEVEL_W'($urandom_range(0, 24'h03FFFF));
            default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        endcase
    endfunction

    // mostly runs of samples closed by a frame tick, with some stray words
    task automatic queue_random(input int n);
        slmb_item_t w;
        int         added;
        int         run_len;
        added = 0;
        while (added < n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1))
                    pending_items.push_back(frame_word());
                else
                begin
                    w.operation = OP_SAMPLE;
                    w.raw_word  = $urandom;
                    w.channel   = 1'($urandom);
                    pending_items.push_back(w);
                end
                added++;
            end
            else
            begin
                run_len = $urandom_range(1, 6);
                repeat (run_len)
                    pending_items.push_back(sample_word(1'($urandom), pick_level()));
                pending_items.push_back(frame_word());
                added += run_len + 1;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SHIFT_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_AVG_SHIFT)
            avg_k = val;
        else
            peak_k = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_shifts(input logic [SHIFT_W-1:0] a, input logic [SHIFT_W-1:0] p);
        write_reg(REG_AVG_SHIFT, a);
        write_reg(REG_PEAK_SHIFT, p);
    endtask

    // wait until every queued word is sent and every expected word is back, then let samples land
    task automatic wait_idle();
        while (pending_items.size() != 0 || push || expected_digits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_raw(input logic ch, input logic [31:0] raw);
        slmb_item_t w;
        w.operation = OP_SAMPLE;
        w.raw_word  = raw;
        w.channel   = ch;
        pending_items.push_back(w);
    endtask

    initial
    begin
        avg_k = AVG_SHIFT_RESET;
        peak_k = PEAK_SHIFT_RESET;
        for (int c = 0; c < 2; c++)
        begin
            level_avg[c] = '0;
            level_pk[c] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: empty frame, word extremes, full scale both signs
        pending_items.push_back(frame_word());
        queue_raw(1'b0, 32'hFFFF_FFFF);
        queue_raw(1'b1, 32'h0000_0000);
        pending_items.push_back(sample_word(1'b0, 24'h7FFFFF));
        pending_items.push_back(sample_word(1'b1, 24'h800000));
        pending_items.push_back(frame_word());
        pending_items.push_back(frame_word());
        wait_idle();

        set_shifts(4'd1, 4'd1);
        pending_items.push_back(sample_word(1'b0, 24'h7FFFFF));
        pending_items.push_back(sample_word(1'b0, 24'h7FFFFF));
        pending_items.push_back(sample_word(1'b1, 24'h800000));
        pending_items.push_back(sample_word(1'b1, 24'h800000));
        pending_items.push_back(frame_word());
        pending_items.push_back(sample_word(1'b0, 24'h060000));
        pending_items.push_back(sample_word(1'b1, 24'h020000));
        pending_items.push_back(frame_word());
        pending_items.push_back(frame_word());
        wait_idle();

        set_shifts(4'd15, 4'd15);
        pending_items.push_back(sample_word(1'b0, 24'h800000));
        pending_items.push_back(sample_word(1'b1, 24'h7FFFFF));
        pending_items.push_back(frame_word());
        wait_idle();

        // zero shift: average follows the sample, peak snaps to the average
        set_shifts(4'd0, 4'd0);
        pending_items.push_back(sample_word(1'b0, 24'h2A0000));
        pending_items.push_back(sample_word(1'b1, 24'hC00000));
        pending_items.push_back(frame_word());
        pending_items.push_back(frame_word());
        wait_idle();

        set_shifts(4'd2, 4'($urandom_range(1, 15)));
        queue_random(30);
        wait_idle();

        // starve the output while frames keep coming so the input backs up
        set_shifts(4'd1, 4'd15);
        hold_req++;
        repeat (12)
        begin
            repeat ($urandom_range(0, 2))
                pending_items.push_back(sample_word(1'($urandom), pick_level()));
            pending_items.push_back(frame_word());
        end
        wait_idle();

        set_shifts(4'($urandom_range(1, 4)), 4'($urandom_range(1, 15)));
        queue_random(30);
        wait_idle();

        set_shifts(4'd3, 4'd1);
        queue_random(30);
        wait_idle();
        repeat (20) @(negedge clk);

        if (error_count == 0)
            $display("stereo_level_meter_bar_tb passed");
        else
            $display("stereo_level_meter_bar_tb failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/slmb_pkg.sv
rtl/core/slmb_front.sv
rtl/core/slmb_frame_queue.sv
rtl/core/slmb_back.sv
rtl/core/stereo_level_meter_bar.sv
tb/stereo_level_meter_bar_tb.sv
